FILE: hw/rtl/rrjt_pkg.sv
// Package for the recency ranked job table: sizes, opcode and run mode codes,
// the stored entry layout and the sequencer state type.
// No dependencies.
`default_nettype none
package rrjt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int PID_W       = 22;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int MODE_W      = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 24;

   typedef enum logic [OP_W-1:0] {
      OP_INIT       = 3'd0,
      OP_PUSH_RUN   = 3'd1,
      OP_PUSH_BG    = 3'd2,
      OP_POP        = 3'd3,
      OP_QUERY_RUN  = 3'd4,
      OP_SUSPEND    = 3'd5,
      OP_QUERY_SUSP = 3'd6
   } opcode_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_RUNNING    = 2'd0,
      MODE_BACKGROUND = 2'd1,
      MODE_SUSPENDED  = 2'd2,
      MODE_TERMINATED = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_FIRST_HIT  = 2'd2
   } status_type;

   typedef struct packed {
      logic [PID_W-1:0] pid;
      mode_type         mode;
      logic [IDX_W-1:0] rank;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK_EX,
      S_WALK_END,
      S_C1_RD,
      S_C1_EX,
      S_C2_RD,
      S_C2_EX,
      S_C3_RD,
      S_C3_EX,
      S_C3_WB,
      S_APPEND,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/rrjt_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module rrjt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/recency_ranked_job_table_core.sv
// Recency ranked job table, top level: request/response streams, the entry
// sequencer and two RAMs. Depends on rrjt_pkg and rrjt_ram.
`default_nettype none
//
//   Channel   Direction   Beat contents
//   req_      in          tdata[2:0] opcode, tdata[24:3] process_id
//   rsp_      out         tdata[21:0] result_pid, tdata[23:22] status
//
// One request beat is taken at a time, only while the sequencer is idle. Init
// and the unused opcode go straight to completion. Pop, suspend and the
// queries walk the stored entries, reading and then examining each one. A push
// compacts the table, of up to 256 entries, in three passes over the entry RAM
// and the rank scratch RAM. The next request is accepted while the response
// still waits for rsp_tready. Reset is synchronous and leaves one running entry
// with pid zero; no clearing pass is needed.
//
module recency_ranked_job_table_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [2:0] opcode, [24:3] process_id, rest zero.
   input  wire logic [rrjt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [21:0] result_pid, [23:22] status.
   output logic      [rrjt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rrjt_pkg::*;

   // Sequencer registers.
   state_type        state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [PID_W-1:0] pid_ff, pid_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] tcnt_ff, tcnt_in;
   logic [CNT_W-1:0] below_ff, below_in;
   logic             full_ff, full_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   entry_type        best_ff, best_in;
   entry_type        cur_ff, cur_in;
   logic [PID_W-1:0] res_ff, res_in;
   status_type       status_ff, status_in;
   logic             e0_valid_ff, e0_valid_in;
   logic             rd_zero_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM ports.
   logic             ent_we, ent_re;
   logic [IDX_W-1:0] ent_wa, ent_ra;
   entry_type        ent_wd, ent_q, ent_rd;
   logic             aux_we, aux_re;
   logic [IDX_W-1:0] aux_wa, aux_ra;
   logic [CNT_W-1:0] aux_wd, aux_q;

   logic [CNT_W-1:0] idx_nx;
   logic             last;
   mode_type         want;

   rrjt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_en   (ent_re),
      .rd_addr (ent_ra),
      .rd_data (ent_q)
   );

   // Scratch RAM indexed by rank: first the terminated flag of each rank, then
   // the number of terminated entries with a lower rank.
   rrjt_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_rank_ram (
      .clock   (clock),
      .wr_en   (aux_we),
      .wr_addr (aux_wa),
      .wr_data (aux_wd),
      .rd_en   (aux_re),
      .rd_addr (aux_ra),
      .rd_data (aux_q)
   );

   // Entry 0 holds the reset entry (pid zero, running, rank zero) until it is
   // first written, so a read of it before then returns zeros.
   assign ent_rd = (rd_zero_ff && !e0_valid_ff) ? entry_type'('0) : ent_q;

   assign idx_nx = idx_ff + CNT_W'(1);
   assign last   = (idx_nx == cnt_ff);
   assign want   = (op_ff == OP_QUERY_SUSP) ? MODE_SUSPENDED : MODE_RUNNING;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= CNT_W'(1);
         e0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         e0_valid_ff  <= e0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      pid_ff      <= pid_in;
      idx_ff      <= idx_in;
      wr_ff       <= wr_in;
      tcnt_ff     <= tcnt_in;
      below_ff    <= below_in;
      full_ff     <= full_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      cur_ff      <= cur_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rd_zero_ff  <= ent_re && (ent_ra == '0);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      idx_in       = idx_ff;
      wr_in        = wr_ff;
      cnt_in       = cnt_ff;
      tcnt_in      = tcnt_ff;
      below_in     = below_ff;
      full_in      = full_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      e0_valid_in  = e0_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ent_we = 1'b0;
      ent_wa = '0;
      ent_wd = '0;
      ent_re = 1'b0;
      ent_ra = idx_ff[IDX_W-1:0];
      aux_we = 1'b0;
      aux_wa = '0;
      aux_wd = '0;
      aux_re = 1'b0;
      aux_ra = idx_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tdata[OP_W-1:0];
               pid_in    = req_tdata[OP_W +: PID_W];
               res_in    = '0;
               status_in = ST_OK;
               idx_in    = '0;
               wr_in     = '0;
               tcnt_in   = '0;
               below_in  = '0;
               full_in   = 1'b0;
               state_in  = S_DONE;
               unique case (req_tdata[OP_W-1:0])
                  OP_INIT: begin
                     ent_we      = 1'b1;
                     ent_wa      = '0;
                     ent_wd      = '{pid: req_tdata[OP_W +: PID_W],
                                     mode: MODE_RUNNING, rank: '0};
                     e0_valid_in = 1'b1;
                     cnt_in      = CNT_W'(1);
                  end
                  OP_PUSH_RUN, OP_PUSH_BG: begin
                     state_in = (cnt_ff == '0) ? S_APPEND : S_C1_RD;
                  end
                  OP_POP, OP_QUERY_RUN, OP_QUERY_SUSP: begin
                     if (cnt_ff != '0) state_in = S_WALK_RD;
                  end
                  OP_SUSPEND: begin
                     if (cnt_ff != '0) state_in = S_WALK_RD;
                     else status_in = ST_FIRST_HIT;
                  end
                  default: ;
               endcase
            end
         end

         // Walk for pop, the queries and suspend.
         S_WALK_RD: begin
            ent_re   = 1'b1;
            state_in = S_WALK_EX;
         end
         S_WALK_EX: begin
            if (op_ff == OP_POP) begin
               if (ent_rd.pid == pid_ff) begin
                  ent_we = 1'b1;
                  ent_wa = idx_ff[IDX_W-1:0];
                  ent_wd = '{pid: ent_rd.pid, mode: MODE_TERMINATED, rank: ent_rd.rank};
                  if (idx_ff == '0) e0_valid_in = 1'b1;
               end
            end else if (idx_ff == '0 ||
                         (ent_rd.mode == want && ent_rd.rank < best_ff.rank)) begin
               best_in     = ent_rd;
               best_idx_in = idx_ff[IDX_W-1:0];
            end
            idx_in   = idx_nx;
            state_in = last ? S_WALK_END : S_WALK_RD;
         end
         S_WALK_END: begin
            if (op_ff == OP_QUERY_RUN || op_ff == OP_QUERY_SUSP) begin
               res_in = best_ff.pid;
            end else if (op_ff == OP_SUSPEND) begin
               if (best_idx_ff == '0) begin
                  status_in = ST_FIRST_HIT;
               end else begin
                  ent_we = 1'b1;
                  ent_wa = best_idx_ff;
                  ent_wd = '{pid: best_ff.pid, mode: MODE_SUSPENDED, rank: best_ff.rank};
               end
            end
            state_in = S_DONE;
         end

         // Compaction, first pass: record which ranks are terminated.
         S_C1_RD: begin
            ent_re   = 1'b1;
            state_in = S_C1_EX;
         end
         S_C1_EX: begin
            aux_we = 1'b1;
            aux_wa = ent_rd.rank;
            aux_wd = (ent_rd.mode == MODE_TERMINATED) ? CNT_W'(1) : '0;
            if (ent_rd.mode == MODE_TERMINATED) tcnt_in = tcnt_ff + CNT_W'(1);
            if (last) begin
               idx_in   = '0;
               state_in = S_C2_RD;
            end else begin
               idx_in   = idx_nx;
               state_in = S_C1_RD;
            end
         end

         // Second pass: in rank order, replace each flag by the count of
         // terminated ranks below it.
         S_C2_RD: begin
            aux_re   = 1'b1;
            state_in = S_C2_EX;
         end
         S_C2_EX: begin
            aux_we   = 1'b1;
            aux_wa   = idx_ff[IDX_W-1:0];
            aux_wd   = below_ff;
            below_in = below_ff + CNT_W'(aux_q[0]);
            if (last) begin
               idx_in   = '0;
               wr_in    = '0;
               full_in  = (cnt_ff == CNT_W'(TABLE_DEPTH)) && (tcnt_ff == '0);
               state_in = S_C3_RD;
            end else begin
               idx_in   = idx_nx;
               state_in = S_C2_RD;
            end
         end

         // Third pass: move survivors down, close the ranks up and age them by
         // one when a new entry will follow.
         S_C3_RD: begin
            ent_re   = 1'b1;
            state_in = S_C3_EX;
         end
         S_C3_EX: begin
            cur_in = ent_rd;
            if (ent_rd.mode == MODE_TERMINATED) begin
               idx_in   = idx_nx;
               state_in = last ? S_APPEND : S_C3_RD;
            end else begin
               aux_re   = 1'b1;
               aux_ra   = ent_rd.rank;
               state_in = S_C3_WB;
            end
         end
         S_C3_WB: begin
            ent_we = 1'b1;
            ent_wa = wr_ff[IDX_W-1:0];
            ent_wd = '{pid: cur_ff.pid, mode: cur_ff.mode,
                       rank: cur_ff.rank - aux_q[IDX_W-1:0]
                             + (full_ff ? IDX_W'(0) : IDX_W'(1))};
            if (wr_ff == '0) e0_valid_in = 1'b1;
            wr_in    = wr_ff + CNT_W'(1);
            idx_in   = idx_nx;
            state_in = last ? S_APPEND : S_C3_RD;
         end

         S_APPEND: begin
            if (full_ff) begin
               status_in = ST_FULL;
               cnt_in    = wr_ff;
            end else begin
               ent_we = 1'b1;
               ent_wa = wr_ff[IDX_W-1:0];
               ent_wd = '{pid: pid_ff,
                          mode: (op_ff == OP_PUSH_BG) ? MODE_BACKGROUND : MODE_RUNNING,
                          rank: '0};
               if (wr_ff == '0) e0_valid_in = 1'b1;
               cnt_in = wr_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {status_ff, res_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // The stored entry count never exceeds the table.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   // Compaction never writes ahead of the entry it is reading.
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_C3_WB) |-> (wr_ff <= idx_ff))
      else $error("compaction write passed the read pointer");

   // A response only appears out of the completion state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside completion");

endmodule
`default_nettype wire
